// ===== hdl/tvcf_pkg.sv =====
// shared constants, types and helpers for the tsdf voxel class fusion block
package tvcf_pkg;

  localparam int DEF_VOXEL_COUNT = 4096;
  localparam int DEF_NUM_SLOTS  = 16;

  localparam int ADDR_W  = 12;
  localparam int DIST_W  = 16;
  localparam int WGT_W   = 16;
  localparam int LABEL_W = 16;
  localparam int CNT_W   = 16;
  localparam int TRUNC_W = 15;
  localparam int SLOT_W  = 4;
  localparam int S_DATA_W = 64;
  localparam int M_DATA_W = 88;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;
  localparam int DVD_W = 33;
  localparam int DVS_W = 17;
  localparam int QUO_W = 17;

  localparam logic [TRUNC_W-1:0] TRUNC_RST  = 15'd4096;
  localparam logic [WGT_W-1:0]   LIMIT_RST  = 16'hffff;
  localparam logic [CNT_W-1:0]   CNT_MAX    = 16'hffff;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_TRUNC_DIST    = 3'd0,
    REG_WEIGHT_LIMIT  = 3'd1,
    REG_OWN_LABEL     = 3'd2,
    REG_CLASS_ENABLE  = 3'd3,
    REG_ACCURATE_MODE = 3'd4
  } cfg_idx_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ,
    ST_MUL1,
    ST_MUL2,
    ST_SUM,
    ST_DIV,
    ST_DONE
  } state_t;

  function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
    sat_inc = (v == CNT_MAX) ? CNT_MAX : v + CNT_W'(1);
  endfunction

endpackage

// ===== hdl/tvcf_ram.sv =====
// generic single-port ram with registered read
module tvcf_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end
endmodule

// ===== hdl/tvcf_div.sv =====
// bit-serial restoring divider, one quotient bit per cycle
module tvcf_div (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  input  logic [tvcf_pkg::DVD_W-1:0] dvd,
  input  logic [tvcf_pkg::DVS_W-1:0] dvs,
  output logic                      done,
  output logic [tvcf_pkg::QUO_W-1:0] quo
);
  import tvcf_pkg::*;

  localparam int CNT_BITS = $clog2(DVD_W + 1);

  logic [DVD_W-1:0]    dvd_sh;
  logic [DVS_W-1:0]    rem;
  logic [DVS_W-1:0]    dvs_r;
  logic [CNT_BITS-1:0] cnt;
  logic                busy;
  logic [DVS_W:0]      trial;
  logic                take;

  assign trial = {rem, dvd_sh[DVD_W-1]};
  assign take  = trial >= {1'b0, dvs_r};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNT_BITS'(DVD_W);
      end else if (busy) begin
        cnt <= cnt - CNT_BITS'(1);
        if (cnt == CNT_BITS'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dvd_sh <= dvd;
      dvs_r  <= dvs;
      rem    <= '0;
      quo    <= '0;
    end else if (busy) begin
      dvd_sh <= {dvd_sh[DVD_W-2:0], 1'b0};
      rem    <= take ? DVS_W'(trial - {1'b0, dvs_r}) : trial[DVS_W-1:0];
      quo    <= {quo[QUO_W-2:0], take};
    end
  end
endmodule

// ===== hdl/tsdf_voxel_class_fusion.sv =====
// top level: tsdf distance and weight fusion with per-voxel class counting
// after reset the block runs a clearing pass that zeroes both rams, in which
// s_tready stays low; config writes are taken during it. afterwards one voxel
// update is worked at a time, and its longest computing step is the 33-step
// bit-serial divider for the weighted average. voxel state sits in one ram and
// the slot counts in a second; an update with an in-range address writes the
// voxel state back, and writes the slot count back only in accurate class mode
// with a valid slot. the result waits in an output register, so the next request
// is taken while the previous result has not yet been consumed.
module tsdf_voxel_class_fusion #(
  parameter int VOXEL_COUNT = tvcf_pkg::DEF_VOXEL_COUNT,
  parameter int NUM_SLOTS  = tvcf_pkg::DEF_NUM_SLOTS
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [tvcf_pkg::CFG_IDX_W-1:0]  cfg_addr,
  input  logic [tvcf_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                            s_tvalid,
  output logic                            s_tready,
  // voxel_addr, obs_dist, obs_weight, label_id
  input  logic [tvcf_pkg::S_DATA_W-1:0]   s_tdata,
  output logic                            m_tvalid,
  input  logic                            m_tready,
  // new_dist, new_weight, best_slot, best_count, own_count, other_count, slot_overflow
  output logic [tvcf_pkg::M_DATA_W-1:0]   m_tdata
);
  import tvcf_pkg::*;

  localparam int VA_W = $clog2(VOXEL_COUNT);
  localparam int SL_W = $clog2(NUM_SLOTS);
  localparam int SA_W = VA_W + SL_W;
  localparam int SLOT_DEPTH = VOXEL_COUNT * (2 ** SL_W);
  localparam int VW = DIST_W + WGT_W + SL_W + 3 * CNT_W;

  state_t state, state_next;

  logic [TRUNC_W-1:0] trunc_dist;
  logic [WGT_W-1:0]   weight_limit;
  logic [LABEL_W-1:0] own_label;
  logic               class_enable;
  logic               accurate_mode;

  logic [ADDR_W-1:0]  in_addr;
  logic [DIST_W-1:0]  in_dist;
  logic [WGT_W-1:0]   in_weight;
  logic [LABEL_W-1:0] in_label;

  logic [SA_W-1:0]    clr_cnt;
  logic               s_fire;
  logic               out_free;
  logic               div_start;
  logic               div_done;
  logic [QUO_W-1:0]   div_quo;
  logic               vox_we;
  logic               slot_we;

  logic [VA_W-1:0]    vidx;
  logic               addr_ok;
  logic               own_hit;
  logic [LABEL_W:0]   slot_full;
  logic               slot_ok;
  logic [VA_W-1:0]    vox_addr;
  logic [SA_W-1:0]    slot_addr;
  logic [VW-1:0]      vox_wdata;
  logic [VW-1:0]      vox_rdata;
  logic [CNT_W-1:0]   slot_wdata;
  logic [CNT_W-1:0]   slot_rdata;

  logic signed [DIST_W-1:0] rd_dist;
  logic [WGT_W-1:0]         rd_weight;
  logic [SL_W-1:0]          rd_bslot;
  logic [CNT_W-1:0]         rd_bcount;
  logic [CNT_W-1:0]         rd_own;
  logic [CNT_W-1:0]         rd_other;

  logic signed [DIST_W:0]   obs_ext;
  logic signed [DIST_W:0]   t_pos;
  logic signed [DIST_W-1:0] clamped;
  logic signed [32:0]       prod_a;
  logic signed [32:0]       prod_b;
  logic signed [33:0]       num;
  logic [DVD_W-1:0]         num_mag;
  logic                     num_neg;
  logic [DVS_W-1:0]         wsum;
  logic [QUO_W-1:0]         quo_signed;

  logic signed [DIST_W-1:0] new_dist;
  logic [WGT_W-1:0]         new_weight;
  logic [SL_W-1:0]          upd_bslot;
  logic [CNT_W-1:0]         upd_bcount;
  logic [CNT_W-1:0]         upd_own;
  logic [CNT_W-1:0]         upd_other;
  logic [CNT_W-1:0]         inc_cnt;
  logic [SLOT_W-1:0]        o_bslot;
  logic [CNT_W-1:0]         o_bcount;
  logic [CNT_W-1:0]         o_own;
  logic [CNT_W-1:0]         o_other;
  logic                     o_ovf;

  assign s_fire   = s_tvalid && s_tready;
  assign out_free = !m_tvalid || m_tready;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      trunc_dist    <= TRUNC_RST;
      weight_limit  <= LIMIT_RST;
      own_label     <= '0;
      class_enable  <= 1'b0;
      accurate_mode <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_idx_t'(cfg_addr))
        REG_TRUNC_DIST:    trunc_dist    <= cfg_data[TRUNC_W-1:0];
        REG_WEIGHT_LIMIT:  weight_limit  <= cfg_data;
        REG_OWN_LABEL:     own_label     <= cfg_data;
        REG_CLASS_ENABLE:  class_enable  <= cfg_data[0];
        REG_ACCURATE_MODE: accurate_mode <= cfg_data[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (s_fire) begin
      in_addr   <= s_tdata[11:0];
      in_dist   <= s_tdata[27:12];
      in_weight <= s_tdata[43:28];
      in_label  <= s_tdata[59:44];
    end
  end

  // state machine
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_CLEAR;
      clr_cnt <= '0;
    end else begin
      state <= state_next;
      if (state == ST_CLEAR) begin
        clr_cnt <= clr_cnt + SA_W'(1);
      end
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_CLEAR: if (clr_cnt == '1) state_next = ST_IDLE;
      ST_IDLE:  if (s_fire) state_next = ST_READ;
      ST_READ:  state_next = addr_ok ? ST_MUL1 : ST_DONE;
      ST_MUL1:  state_next = ST_MUL2;
      ST_MUL2:  state_next = ST_SUM;
      ST_SUM:   state_next = ST_DIV;
      ST_DIV:   if (div_done) state_next = ST_DONE;
      ST_DONE:  if (out_free) state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    s_tready  = 1'b0;
    div_start = 1'b0;
    vox_we    = 1'b0;
    slot_we   = 1'b0;
    case (state)
      ST_CLEAR: begin
        vox_we  = 1'b1;
        slot_we = 1'b1;
      end
      ST_IDLE: s_tready = 1'b1;
      ST_SUM:  div_start = 1'b1;
      ST_DONE: begin
        vox_we  = out_free && addr_ok;
        slot_we = out_free && addr_ok && class_enable && accurate_mode && slot_ok;
      end
      default: ;
    endcase
  end

  // addressing
  assign addr_ok   = {5'd0, in_addr} < 17'(VOXEL_COUNT);
  assign vidx      = VA_W'({4'd0, in_addr});
  assign own_hit   = in_label == own_label;
  assign slot_full = own_hit ? '0 : {1'b0, in_label} + 17'd1;
  assign slot_ok   = slot_full < 17'(NUM_SLOTS);
  assign vox_addr  = (state == ST_CLEAR) ? clr_cnt[VA_W-1:0] : vidx;
  assign slot_addr = (state == ST_CLEAR) ? clr_cnt : {vidx, slot_full[SL_W-1:0]};

  tvcf_ram #(.WIDTH(VW), .DEPTH(VOXEL_COUNT)) u_vox_ram (
    .clk   (clk),
    .we    (vox_we),
    .addr  (vox_addr),
    .wdata (vox_wdata),
    .rdata (vox_rdata)
  );

  tvcf_ram #(.WIDTH(CNT_W), .DEPTH(SLOT_DEPTH)) u_slot_ram (
    .clk   (clk),
    .we    (slot_we),
    .addr  (slot_addr),
    .wdata (slot_wdata),
    .rdata (slot_rdata)
  );

  assign {rd_other, rd_own, rd_bcount, rd_bslot, rd_weight, rd_dist} = vox_rdata;

  // fusion datapath
  assign obs_ext = {in_dist[DIST_W-1], in_dist};
  assign t_pos   = {2'b00, trunc_dist};

  always_comb begin
    clamped = in_dist;
    if (obs_ext > t_pos) clamped = DIST_W'(t_pos);
    if (obs_ext < -t_pos) clamped = DIST_W'(-t_pos);
  end

  always_ff @(posedge clk) begin
    if (state == ST_MUL1) begin
      prod_a <= rd_dist * $signed({1'b0, rd_weight});
      wsum   <= {1'b0, rd_weight} + {1'b0, in_weight};
    end
    if (state == ST_MUL2) begin
      prod_b <= clamped * $signed({1'b0, in_weight});
    end
    if (state == ST_SUM) begin
      num_neg <= num[33];
    end
  end

  assign num     = {prod_a[32], prod_a} + {prod_b[32], prod_b};
  assign num_mag = num[33] ? DVD_W'(-num) : num[DVD_W-1:0];

  tvcf_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .dvd   (num_mag),
    .dvs   (wsum),
    .done  (div_done),
    .quo   (div_quo)
  );

  always_ff @(posedge clk) begin
    if (div_done) begin
      quo_signed <= num_neg ? -div_quo : div_quo;
    end
  end

  assign new_dist   = (wsum == '0) ? rd_dist : quo_signed[DIST_W-1:0];
  assign new_weight = (wsum < {1'b0, weight_limit}) ? wsum[WGT_W-1:0] : weight_limit;

  // class tracking
  assign inc_cnt    = sat_inc(slot_rdata);
  assign slot_wdata = (state == ST_CLEAR) ? '0 : inc_cnt;

  always_comb begin
    upd_bslot  = rd_bslot;
    upd_bcount = rd_bcount;
    upd_own    = rd_own;
    upd_other  = rd_other;
    o_bslot    = '0;
    o_bcount   = '0;
    o_own      = '0;
    o_other    = '0;
    o_ovf      = 1'b0;
    if (class_enable) begin
      if (accurate_mode) begin
        if (!slot_ok) begin
          o_ovf = 1'b1;
        end else if (inc_cnt > rd_bcount) begin
          upd_bcount = inc_cnt;
          upd_bslot  = slot_full[SL_W-1:0];
        end
        o_bslot  = SLOT_W'({{(LABEL_W+1){1'b0}}, upd_bslot});
        o_bcount = upd_bcount;
      end else begin
        if (own_hit) upd_own = sat_inc(rd_own);
        else upd_other = sat_inc(rd_other);
        o_own   = upd_own;
        o_other = upd_other;
      end
    end
  end

  assign vox_wdata = (state == ST_CLEAR) ? '0 :
      {upd_other, upd_own, upd_bcount, upd_bslot, new_weight, new_dist};

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (state == ST_DONE && out_free) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_DONE && out_free) begin
      if (addr_ok) begin
        m_tdata <= {3'd0, o_ovf, o_other, o_own, o_bcount, o_bslot, new_weight, new_dist};
      end else begin
        m_tdata <= '0;
      end
    end
  end
endmodule

// ===== hdl/tvcf_checker.sv =====
// port-level checker for the tsdf voxel class fusion block
module tvcf_checker (
  input logic                            clk,
  input logic                            rst,
  input logic                            s_tvalid,
  input logic                            s_tready,
  input logic                            m_tvalid,
  input logic                            m_tready,
  input logic [tvcf_pkg::M_DATA_W-1:0]   m_tdata
);
  import tvcf_pkg::*;

  a_rst_quiet: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result valid after reset");

  a_hold: assert property (@(posedge clk) disable iff (rst)
      m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("stalled result changed");

  a_one_flight: assert property (@(posedge clk) disable iff (rst)
      s_tvalid && s_tready |=> !s_tready)
    else $error("second request taken while busy");

  a_best_count: assert property (@(posedge clk) disable iff (rst)
      m_tvalid && (m_tdata[35:32] != 4'd0) |-> (m_tdata[51:36] != 16'd0))
    else $error("best slot without count");

  a_mode_excl: assert property (@(posedge clk) disable iff (rst)
      m_tvalid && (m_tdata[51:36] != 16'd0) |-> (m_tdata[83:52] == 32'd0))
    else $error("accurate and simple counters both set");
endmodule

bind tsdf_voxel_class_fusion tvcf_checker u_tvcf_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);
